/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside of reset.
`define DCF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property whose consequence is checked in the cycle after its trigger.
`define DCF_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* src/dcf_pkg.sv */
package dcf_pkg;

  localparam int CH_FIELD_W    = 4;
  localparam int SAMPLE_IN_W   = 16;
  localparam int SAMPLE_W      = 14;
  localparam int LIM_W         = 14;
  localparam int WIN_W         = 5;
  localparam int SMOOTH_W      = 22;
  localparam int CFG_W         = 14;
  localparam int CFG_IDX_W     = 2;

  localparam int CHANNELS_DEF  = 16;
  localparam int FRAC_BITS_DEF = 8;

  // Quotient bits produced per divider cycle.
  localparam int DIV_BITS      = 4;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [LIM_W-1:0] DESPIKE_RST = LIM_W'(2000);
  localparam logic [WIN_W-1:0] WINDOW_RST  = WIN_W'(5);
  localparam logic [LIM_W-1:0] UPPER_RST   = LIM_W'(10000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DESPIKE = 2'd0,
    REG_WINDOW  = 2'd1,
    REG_UPPER   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SPIKE = 2'd2
  } status_t;

  typedef struct packed {
    logic [CH_FIELD_W-1:0]         channel;
    logic signed [SAMPLE_IN_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [CH_FIELD_W-1:0] channel_echo;
    status_t               status;
    logic [SMOOTH_W-1:0]   smoothed;
  } out_item_t;

  typedef struct packed {
    logic [LIM_W-1:0] despike_limit;
    logic [WIN_W-1:0] smoothing_window;
    logic [LIM_W-1:0] upper_limit;
  } cfg_t;

  // Classified beat handed from the front to the back.
  typedef struct packed {
    logic                  in_range;
    logic [CH_FIELD_W-1:0] channel;
    logic [SAMPLE_W-1:0]   sample;
  } cls_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_ctrl_t;

endpackage

/* src/dcf_front.sv */
module dcf_front #(
  parameter int CHANNELS = dcf_pkg::CHANNELS_DEF
) (
  input  logic              in_valid,
  input  dcf_pkg::in_item_t in_data,
  input  dcf_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              in_stall,
  output logic              push,
  output dcf_pkg::cls_item_t push_item
);

  logic positive;
  logic below_upper;
  logic ch_ok;

  // A positive sample has its sign bit clear and is not zero.
  assign positive    = !in_data.sample[dcf_pkg::SAMPLE_IN_W-1] && (in_data.sample != '0);
  assign below_upper = in_data.sample[dcf_pkg::SAMPLE_IN_W-2:0] <
                       (dcf_pkg::SAMPLE_IN_W-1)'(cfg.upper_limit);
  assign ch_ok       = int'(in_data.channel) < CHANNELS;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign push_item.in_range = positive && below_upper && ch_ok;
  assign push_item.channel  = in_data.channel;
  assign push_item.sample   = in_data.sample[dcf_pkg::SAMPLE_W-1:0];

endmodule

/* src/dcf_queue.sv */
module dcf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dcf_pkg::cls_item_t  push_item,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output dcf_pkg::cls_item_t  head
);

  `include "assert_macros.svh"

  localparam int PTR_W = (dcf_pkg::QUEUE_DEPTH > 1) ? $clog2(dcf_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(dcf_pkg::QUEUE_DEPTH + 1);

  dcf_pkg::cls_item_t entry_r [dcf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  assign full  = (count_r == CNT_W'(dcf_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(dcf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(dcf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  `DCF_ASSERT_RST(a_q_no_overflow, push |-> !full, "queue push while full")
  `DCF_ASSERT_RST(a_q_no_underflow, pop |-> !empty, "queue pop while empty")
  `DCF_ASSERT_NXT(a_q_drain, pop && !push && (count_r == CNT_W'(1)), empty, "queue not empty after last pop")

endmodule

/* src/dcf_back.sv */
module dcf_back #(
  parameter int CHANNELS  = dcf_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dcf_pkg::cfg_t       cfg,
  input  logic                q_empty,
  input  dcf_pkg::cls_item_t  head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output dcf_pkg::out_item_t  out_data
);

  `include "assert_macros.svh"

  localparam int FRAC_BITS = dcf_pkg::FRAC_BITS_DEF;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AVG_W     = dcf_pkg::SAMPLE_W + FRAC_BITS;
  localparam int NUM_W     = AVG_W + dcf_pkg::WIN_W;
  localparam int DIV_STEPS = (NUM_W + dcf_pkg::DIV_BITS - 1) / dcf_pkg::DIV_BITS;
  localparam int NUM_PAD   = DIV_STEPS * dcf_pkg::DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int WIN_W     = dcf_pkg::WIN_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic [AVG_W-1:0]    avg_mem [CHANNELS];
  logic [CHANNELS-1:0] seen_r;

  logic [dcf_pkg::CH_FIELD_W-1:0] ch_r;
  logic [dcf_pkg::SAMPLE_W-1:0]   smp_r;
  logic [AVG_W-1:0]               avg_rd_r;
  logic                           seen_rd_r;
  logic [WIN_W-1:0]               w_r;
  logic [NUM_PAD-1:0]             quo_r;
  logic [WIN_W-1:0]               rem_r;
  logic [STEP_W-1:0]              step_r;
  logic [AVG_W-1:0]               res_r;
  dcf_pkg::status_t               status_r;
  logic                           out_valid_r;
  dcf_pkg::out_item_t             out_data_r;

  logic [CH_W-1:0]    head_idx;
  logic [CH_W-1:0]    idx;
  logic [AVG_W-1:0]   s_fx;
  logic [AVG_W-1:0]   avg;
  logic [AVG_W-1:0]   gap;
  logic [AVG_W-1:0]   limit_fx;
  logic               pass;
  logic [WIN_W-1:0]   w_eff;
  logic [NUM_W-1:0]   prod;
  logic [NUM_PAD-1:0] num;
  logic [NUM_PAD-1:0] quo_c;
  logic [WIN_W-1:0]   rem_c;
  logic               div_last;
  logic               out_load;
  logic               mem_we;
  logic [AVG_W-1:0]   mem_wdata;

  assign head_idx = CH_W'(head.channel);
  assign idx      = CH_W'(ch_r);

  assign s_fx     = AVG_W'(smp_r) << FRAC_BITS;
  assign avg      = seen_rd_r ? avg_rd_r : s_fx;
  assign gap      = (avg >= s_fx) ? (avg - s_fx) : (s_fx - avg);
  assign limit_fx = AVG_W'(cfg.despike_limit) << FRAC_BITS;
  assign pass     = gap < limit_fx;

  // A window of zero behaves as a window of one.
  assign w_eff = (cfg.smoothing_window == '0) ? WIN_W'(1) : cfg.smoothing_window;
  assign prod  = {{AVG_W{1'b0}}, w_eff - WIN_W'(1)} * {{WIN_W{1'b0}}, avg};
  assign num   = NUM_PAD'(prod) + NUM_PAD'(s_fx);

  // Restoring division, DIV_BITS quotient bits per cycle. The numerator
  // shifts out of the top of quo_r while quotient bits enter at the bottom.
  always_comb begin
    logic [WIN_W:0] t;
    rem_c = rem_r;
    quo_c = quo_r;
    t     = '0;
    for (int k = 0; k < dcf_pkg::DIV_BITS; k++) begin
      t     = {rem_c, quo_c[NUM_PAD-1]};
      quo_c = {quo_c[NUM_PAD-2:0], 1'b0};
      if (t >= {1'b0, w_r}) begin
        rem_c    = WIN_W'(t - {1'b0, w_r});
        quo_c[0] = 1'b1;
      end else begin
        rem_c = t[WIN_W-1:0];
      end
    end
  end

  assign div_last = (step_r == STEP_W'(DIV_STEPS - 1));
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign pop      = (state_r == S_IDLE) && !q_empty;

  // The seeding sample is stored at once, even if it is later rejected.
  assign mem_we    = ((state_r == S_CALC) && !seen_rd_r) || ((state_r == S_DIV) && div_last);
  assign mem_wdata = (state_r == S_DIV) ? AVG_W'(quo_c) : s_fx;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          state_nxt = head.in_range ? S_CALC : S_OUT;
        end
      end
      S_CALC: state_nxt = pass ? S_DIV : S_OUT;
      S_DIV:  state_nxt = div_last ? S_OUT : S_DIV;
      S_OUT:  state_nxt = out_load ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_CALC) && !seen_rd_r) begin
        seen_r[idx] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      avg_mem[idx] <= mem_wdata;
    end
    if (pop) begin
      avg_rd_r <= avg_mem[head_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ch_r      <= head.channel;
      smp_r     <= head.sample;
      seen_rd_r <= seen_r[head_idx];
      status_r  <= dcf_pkg::ST_RANGE;
      res_r     <= '0;
    end
    if (state_r == S_CALC) begin
      w_r    <= w_eff;
      quo_r  <= num;
      rem_r  <= '0;
      step_r <= '0;
      if (!pass) begin
        status_r <= dcf_pkg::ST_SPIKE;
      end
    end
    if (state_r == S_DIV) begin
      quo_r  <= quo_c;
      rem_r  <= rem_c;
      step_r <= step_r + STEP_W'(1);
      if (div_last) begin
        status_r <= dcf_pkg::ST_OK;
        res_r    <= AVG_W'(quo_c);
      end
    end
    if (out_load) begin
      out_data_r.channel_echo <= ch_r;
      out_data_r.status       <= status_r;
      out_data_r.smoothed     <= dcf_pkg::SMOOTH_W'(res_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `DCF_ASSERT_RST(a_div_nonzero, (state_r == S_DIV) |-> (w_r != '0), "divider runs with zero divisor")
  `DCF_ASSERT_RST(a_zero_unless_ok, (out_valid_r && (out_data_r.status != dcf_pkg::ST_OK)) |-> (out_data_r.smoothed == '0), "nonzero average on a rejected beat")
  `DCF_ASSERT_NXT(a_seed_marks, (state_r == S_CALC) && !seen_rd_r, seen_r[idx], "seeded channel not marked as seen")

endmodule

/* src/despiked_ema_channel_filter_unit.sv */
// Channel | Direction | Handshake           | Beat
// in      | input     | in_valid/in_stall   | channel, sample
// out     | output    | out_valid/out_stall | channel_echo, status, smoothed
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// An accepted beat passes through the back end's idle, calc, divide and output
// states, the divide state running the shared 4-bit-per-cycle divider. A beat
// rejected as a spike skips the divide state and an out-of-range beat goes from
// idle straight to output. A two-entry queue takes new beats while the back end
// works or the output register waits on out_stall.
// Reset clears the seen flags and the queue and sets the configuration
// registers to their defaults at once; there is no clearing pass.
module despiked_ema_channel_filter_unit #(
  parameter int CHANNELS  = dcf_pkg::CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dcf_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dcf_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [dcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dcf_pkg::CFG_W-1:0]       cfg_data
);

  dcf_pkg::cfg_t      cfg_r;
  dcf_pkg::cls_item_t push_item;
  dcf_pkg::cls_item_t head;
  dcf_pkg::q_ctrl_t   qc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.despike_limit    <= dcf_pkg::DESPIKE_RST;
      cfg_r.smoothing_window <= dcf_pkg::WINDOW_RST;
      cfg_r.upper_limit      <= dcf_pkg::UPPER_RST;
    end else if (cfg_we) begin
      unique case (dcf_pkg::reg_idx_t'(cfg_index))
        dcf_pkg::REG_DESPIKE: cfg_r.despike_limit    <= cfg_data[dcf_pkg::LIM_W-1:0];
        dcf_pkg::REG_WINDOW:  cfg_r.smoothing_window <= cfg_data[dcf_pkg::WIN_W-1:0];
        dcf_pkg::REG_UPPER:   cfg_r.upper_limit      <= cfg_data[dcf_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  dcf_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (qc.full),
    .in_stall (in_stall),
    .push     (qc.push),
    .push_item(push_item)
  );

  dcf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (qc.push),
    .push_item(push_item),
    .pop      (qc.pop),
    .full     (qc.full),
    .empty    (qc.empty),
    .head     (head)
  );

  dcf_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (qc.empty),
    .head     (head),
    .pop      (qc.pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

/* verif/dcf_checker.sv */
module dcf_checker
  import dcf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   errors,
  output int                   pending,
  output int                   n_ok,
  output int                   n_range,
  output int                   n_spike
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [LIM_W-1:0]    spike_lim;
  logic [WIN_W-1:0]    window;
  logic [LIM_W-1:0]    upper;
  logic [SMOOTH_W-1:0] avg_mem [CHANNELS_DEF];
  logic                seen [CHANNELS_DEF];
  out_item_t           result_q [$];

  initial begin
    errors  = 0;
    pending = 0;
    n_ok    = 0;
    n_range = 0;
    n_spike = 0;
  end

  // Classifies one input beat, seeds the channel average on its first in-range beat and updates it on a pass.
  function automatic out_item_t filter_beat(in_item_t b);
    out_item_t   r;
    logic [15:0] raw;
    logic [31:0] s_fx;
    logic [31:0] avg;
    logic [31:0] gap;
    logic [31:0] w;
    logic [31:0] na;
    raw = b.sample;
    r.channel_echo = b.channel;
    r.status = ST_RANGE;
    r.smoothed = '0;
    if (raw != 16'd0 && !raw[15] && raw < {2'b00, upper}) begin
      s_fx = {16'd0, raw} << FRAC_BITS_DEF;
      if (!seen[b.channel]) begin
        avg_mem[b.channel] = s_fx[SMOOTH_W-1:0];
        seen[b.channel] = 1'b1;
      end
      avg = {10'd0, avg_mem[b.channel]};
      gap = (avg >= s_fx) ? (avg - s_fx) : (s_fx - avg);
      if (gap < ({18'd0, spike_lim} << FRAC_BITS_DEF)) begin
        // A window of zero behaves like a window of one.
        w = (window == '0) ? 32'd1 : {27'd0, window};
        na = ((w - 32'd1) * avg + s_fx) / w;
        avg_mem[b.channel] = na[SMOOTH_W-1:0];
        r.smoothed = na[SMOOTH_W-1:0];
        r.status = ST_OK;
      end else begin
        r.status = ST_SPIKE;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      spike_lim = DESPIKE_RST;
      window    = WINDOW_RST;
      upper     = UPPER_RST;
      for (int i = 0; i < CHANNELS_DEF; i++) begin
        seen[i] = 1'b0;
        avg_mem[i] = '0;
      end
      result_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DESPIKE: spike_lim = cfg_data[LIM_W-1:0];
          REG_WINDOW:  window = cfg_data[WIN_W-1:0];
          REG_UPPER:   upper = cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
      // Results are checked before new inputs so a same-edge beat cannot match.
      if (out_valid && !out_stall) begin
        got = out_data;
        if (result_q.size() == 0) begin
          $error("unexpected result beat: channel_echo %0d status %0d smoothed %0d",
                 got.channel_echo, got.status, got.smoothed);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (got.channel_echo !== want.channel_echo) begin
            $error("channel_echo: expected %0d, actual %0d",
                   want.channel_echo, got.channel_echo);
            errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
          end
          if (got.smoothed !== want.smoothed) begin
            $error("smoothed: expected %0d, actual %0d", want.smoothed, got.smoothed);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = filter_beat(in_data);
        case (want.status)
          ST_OK:    n_ok++;
          ST_SPIKE: n_spike++;
          default:  n_range++;
        endcase
        result_q.push_back(want);
      end
    end
    pending = result_q.size();
  end

endmodule

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dcf_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int errors;
  int pending;
  int n_ok;
  int n_range;
  int n_spike;

  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int cur_d = 2000;
  int cur_u = 10000;
  int lvl [16];
  int n_sent = 0;
  int n_settings = 1;

  always #4 clk = ~clk;

  despiked_ema_channel_filter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dcf_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .n_ok      (n_ok),
    .n_range   (n_range),
    .n_spike   (n_spike)
  );

  // The receiver switches between stall styles, each held for a random span.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
    endcase
  end

  initial begin
    #(5_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Called at a falling edge; returns at a falling edge after the beat is taken.
  task automatic send_beat(input int ch, input int smp);
    in_data.channel <= 4'(ch);
    in_data.sample <= 16'(smp);
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    n_sent++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic set_regs(input int d, input int w, input int u);
    cfg_we <= 1'b1;
    cfg_index <= REG_DESPIKE;
    cfg_data <= CFG_W'(d);
    @(negedge clk);
    cfg_index <= REG_WINDOW;
    cfg_data <= CFG_W'(w);
    @(negedge clk);
    cfg_index <= REG_UPPER;
    cfg_data <= CFG_W'(u);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_d = d;
    cur_u = u;
    n_settings++;
  endtask

  // Mostly samples that wander near a per-channel level so the averages
  // keep moving, with some boundary probes and some raw noise.
  function automatic int pick_sample(int ch);
    int r;
    int span;
    int q;
    int d2;
    int top;
    r = $urandom_range(0, 99);
    span = (cur_d > 0) ? cur_d : 1;
    top = (cur_u > 1) ? cur_u - 1 : 1;
    if (r < 12) begin
      return int'($urandom_range(0, 65535));
    end
    if (r < 16) begin
      case ($urandom_range(0, 5))
        0: return 0;
        1: return 1;
        2: return cur_u - 1;
        3: return cur_u;
        4: return 32767;
        default: return -1;
      endcase
    end
    if (r < 26) begin
      d2 = cur_d - 1 + int'($urandom_range(0, 2));
      return ($urandom_range(0, 1) == 0) ? lvl[ch] + d2 : lvl[ch] - d2;
    end
    q = span / 8;
    lvl[ch] = lvl[ch] + int'($urandom_range(0, 2 * q)) - q;
    if (lvl[ch] < 1) lvl[ch] = 1;
    if (lvl[ch] > top) lvl[ch] = top;
    d2 = span / 2;
    return lvl[ch] + int'($urandom_range(0, 2 * d2)) - d2;
  endfunction

  task automatic run_random(input int d, input int w, input int u, input int n);
    int ch;
    set_regs(d, w, u);
    for (int i = 0; i < n; i++) begin
      ch = $urandom_range(0, 15);
      send_beat(ch, pick_sample(ch));
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < 16; i++) lvl[i] = $urandom_range(100, 9000);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: range edges, seeding and the exact spike boundary.
    send_beat(0, 0);
    send_beat(0, -1);
    send_beat(0, -32768);
    send_beat(0, 32767);
    send_beat(0, 10000);
    send_beat(1, 9999);
    send_beat(2, 1);
    send_beat(2, 2001);
    send_beat(2, 2000);
    send_beat(3, 5000);
    send_beat(3, 16000);
    send_beat(15, 1234);
    drain();

    // A zero despike limit still seeds, then rejects everything.
    set_regs(0, 5, 16383);
    send_beat(4, 100);
    send_beat(4, 100);
    send_beat(1, 9999);
    drain();

    // Zero window makes the average jump to the sample.
    set_regs(16383, 0, 16383);
    send_beat(5, 16382);
    send_beat(5, 1);
    send_beat(2, 8000);
    drain();

    // Zero upper limit: nothing is in range.
    set_regs(16383, 31, 0);
    send_beat(6, 1);
    send_beat(6, 16383);
    drain();

    set_regs(100, 31, 16383);
    send_beat(7, 500);
    send_beat(7, 599);
    send_beat(7, 400);
    drain();

    run_random(2000, 5, 10000, 300);
    run_random(16383, 16, 16383, 250);
    run_random(40, 1, 16383, 250);
    run_random(16383, 4, 5000, 200);
    run_random(700, 31, 16383, 200);
    run_random(900, 0, 12000, 200);
    run_random(0, 7, 16383, 100);
    run_random(1, 2, 16383, 100);
    run_random(3000, 9, 1, 100);

    $display("Sent %0d beats over %0d register settings, receiver and sender idling.",
             n_sent, n_settings);
    $display("Results: %0d accepted, %0d out of range, %0d rejected as spikes.",
             n_ok, n_range, n_spike);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/dcf_pkg.sv
src/dcf_front.sv
src/dcf_queue.sv
src/dcf_back.sv
src/despiked_ema_channel_filter_unit.sv
verif/dcf_checker.sv
verif/tb.sv
